// File: rtl/core/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared types, widths and helpers for the bilinear quad face pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bqf_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam int NRM_W  = 48;
  localparam int RAD_W  = 126;
  localparam int ROOT_W = 63;
  localparam int REM_W  = 65;
  localparam int SQ_STEPS = 63;

  localparam int DREM_W = 63;
  localparam int QUO_W  = 32;
  localparam int DV_STEPS = 32;

  typedef struct packed {
    logic [2:0][31:0]      phys;
    logic [2:0][NRM_W-1:0] nrm;
  } side_t;

  function automatic logic [NRM_W-1:0] mag48(input logic [NRM_W-1:0] v);
    return v[NRM_W-1] ? (~v + NRM_W'(1)) : v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bilinear_quad_face_geometry.sv
// ----------------------------------------------------------------------------
// bilinear_quad_face_geometry
// Bilinear quad face map: point, weighted normal, surface measure, unit normal.
// ----------------------------------------------------------------------------
// A request with func clear writes one corner and takes effect for the very
// next request; it produces no result. A request with func set is evaluated
// in a fully pipelined datapath that accepts one request every cycle while
// not stalled and passes it through seven arithmetic stages, 63 square root
// stages (one root bit each) and 32 divider stages (one quotient bit each),
// then the output register. A stall on the output holds the whole pipeline,
// so in_stall follows out_valid and out_stall.
`default_nettype none

module bilinear_quad_face_geometry #(
  parameter int COORD_WIDTH = bqf_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [1:0]         corner_index,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic signed [16:0] ref_s,
  input  logic signed [16:0] ref_t,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] phys_x,
  output logic signed [31:0] phys_y,
  output logic signed [31:0] phys_z,
  output logic signed [47:0] area_normal_x,
  output logic signed [47:0] area_normal_y,
  output logic signed [47:0] area_normal_z,
  output logic [46:0]        surface_measure,
  output logic signed [31:0] unit_normal_x,
  output logic signed [31:0] unit_normal_y,
  output logic signed [31:0] unit_normal_z,
  output logic               degenerate
);
  import bqf_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int JPW = DW + 18;
  localparam int JSW = JPW + 1;
  localparam int MPW = CW + 34;
  localparam int MSW = MPW + 2;

  localparam logic signed [48:0] CMAX = (49'sd1 <<< (CW - 1)) - 49'sd1;
  localparam logic signed [48:0] CMIN = -CMAX - 49'sd1;
  localparam logic signed [JSW-1:0] JHALF = JSW'(64'sd65536);
  localparam logic signed [MSW-1:0] MHALF = MSW'(64'sd2147483648);
  localparam logic signed [64:0] NHALF = 65'sd32768;
  localparam logic signed [64:0] NMAX  = (65'sd1 <<< 47) - 65'sd1;
  localparam logic signed [64:0] NMIN  = -NMAX - 65'sd1;
  localparam logic [48:0] MEAS_MAX = (49'd1 << 47) - 49'd1;
  localparam logic [31:0] UNIT_ONE = 32'd1 << 30;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [CW-1:0] sat_coord(input logic signed [31:0] v);
    logic signed [48:0] w;
    w = 49'(v);
    if (w > CMAX) w = CMAX;
    if (w < CMIN) w = CMIN;
    return w[CW-1:0];
  endfunction

  function automatic logic [16:0] clamp_ref(input logic signed [16:0] v);
    if (v > 17'sd32768) return 17'd32768;
    if (v < -17'sd32768) return -17'sd32768;
    return v;
  endfunction

  logic en;
  logic in_acc;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign in_acc   = in_valid && en;

  // Corner store.
  logic [2:0][3:0][CW-1:0] store;
  logic [2:0][31:0] coord_in;
  assign coord_in = {coord_z, coord_y, coord_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      store <= '0;
    end else if (in_acc && func == FUNC_LOAD) begin
      for (int k = 0; k < 3; k++) store[k][corner_index] <= sat_coord(coord_in[k]);
    end
  end

  // Stage A: weights, corners and edge differences.
  logic                    a_vld;
  logic [3:0][16:0]        a_w;
  logic [2:0][3:0][CW-1:0] a_c;
  logic [2:0][3:0][DW-1:0] a_d;
  logic [3:0][16:0]        a_w_next;
  logic [2:0][3:0][DW-1:0] a_d_next;

  always_comb begin
    logic signed [17:0] sc;
    logic signed [17:0] tc;
    logic signed [17:0] tmp;
    sc = 18'($signed(clamp_ref(ref_s)));
    tc = 18'($signed(clamp_ref(ref_t)));
    tmp = 18'sd32768 - sc; a_w_next[0] = tmp[16:0];
    tmp = 18'sd32768 + sc; a_w_next[1] = tmp[16:0];
    tmp = 18'sd32768 - tc; a_w_next[2] = tmp[16:0];
    tmp = 18'sd32768 + tc; a_w_next[3] = tmp[16:0];
    for (int k = 0; k < 3; k++) begin
      a_d_next[k][0] = DW'($signed(store[k][1])) - DW'($signed(store[k][0]));
      a_d_next[k][1] = DW'($signed(store[k][2])) - DW'($signed(store[k][3]));
      a_d_next[k][2] = DW'($signed(store[k][3])) - DW'($signed(store[k][0]));
      a_d_next[k][3] = DW'($signed(store[k][2])) - DW'($signed(store[k][1]));
    end
  end

  // Stage B: shape products and Jacobian partial products.
  logic                     b_vld;
  logic [3:0][32:0]         b_p;
  logic [2:0][3:0][CW-1:0]  b_c;
  logic [2:0][3:0][JPW-1:0] b_jp;
  logic [3:0][32:0]         b_p_next;
  logic [2:0][3:0][JPW-1:0] b_jp_next;

  always_comb begin
    logic [33:0] pr;
    pr = a_w[0] * a_w[2]; b_p_next[0] = pr[32:0];
    pr = a_w[1] * a_w[2]; b_p_next[1] = pr[32:0];
    pr = a_w[1] * a_w[3]; b_p_next[2] = pr[32:0];
    pr = a_w[0] * a_w[3]; b_p_next[3] = pr[32:0];
    for (int k = 0; k < 3; k++) begin
      b_jp_next[k][0] = $signed({1'b0, a_w[2]}) * $signed(a_d[k][0]);
      b_jp_next[k][1] = $signed({1'b0, a_w[3]}) * $signed(a_d[k][1]);
      b_jp_next[k][2] = $signed({1'b0, a_w[0]}) * $signed(a_d[k][2]);
      b_jp_next[k][3] = $signed({1'b0, a_w[1]}) * $signed(a_d[k][3]);
    end
  end

  // Stage C: map products and rounded Jacobian columns.
  logic                     c_vld;
  logic [2:0][3:0][MPW-1:0] c_mp;
  logic [2:0][31:0]         c_jd;
  logic [2:0][31:0]         c_je;
  logic [2:0][3:0][MPW-1:0] c_mp_next;
  logic [2:0][31:0]         c_jd_next;
  logic [2:0][31:0]         c_je_next;

  always_comb begin
    logic signed [JSW-1:0] js;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 4; i++) begin
        c_mp_next[k][i] = $signed({1'b0, b_p[i]}) * $signed(b_c[k][i]);
      end
      js = $signed(b_jp[k][0]) + $signed(b_jp[k][1]) + JHALF;
      js = js >>> 17;
      c_jd_next[k] = sat32(64'(js));
      js = $signed(b_jp[k][2]) + $signed(b_jp[k][3]) + JHALF;
      js = js >>> 17;
      c_je_next[k] = sat32(64'(js));
    end
  end

  // Stage D: mapped point and cross products.
  logic             d_vld;
  logic [2:0][31:0] d_phys;
  logic [5:0][63:0] d_x;
  logic [2:0][31:0] d_phys_next;
  logic [5:0][63:0] d_x_next;

  always_comb begin
    logic signed [MSW-1:0] ms;
    for (int k = 0; k < 3; k++) begin
      ms = $signed(c_mp[k][0]) + $signed(c_mp[k][1]) + $signed(c_mp[k][2])
         + $signed(c_mp[k][3]) + MHALF;
      ms = ms >>> 32;
      d_phys_next[k] = sat32(64'(ms));
    end
    d_x_next[0] = $signed(c_jd[1]) * $signed(c_je[2]);
    d_x_next[1] = $signed(c_jd[2]) * $signed(c_je[1]);
    d_x_next[2] = $signed(c_jd[2]) * $signed(c_je[0]);
    d_x_next[3] = $signed(c_jd[0]) * $signed(c_je[2]);
    d_x_next[4] = $signed(c_jd[0]) * $signed(c_je[1]);
    d_x_next[5] = $signed(c_jd[1]) * $signed(c_je[0]);
  end

  // Stage E: rounded and saturated weighted normal.
  logic  e_vld;
  side_t e_side;
  side_t e_side_next;

  always_comb begin
    logic signed [64:0] df;
    e_side_next.phys = d_phys;
    for (int k = 0; k < 3; k++) begin
      df = $signed(d_x[2*k]) - $signed(d_x[2*k+1]) + NHALF;
      df = df >>> 16;
      if (df > NMAX) df = NMAX;
      if (df < NMIN) df = NMIN;
      e_side_next.nrm[k] = df[NRM_W-1:0];
    end
  end

  // Stage F: partial squares of the normal magnitudes.
  logic             f_vld;
  side_t            f_side;
  logic [2:0][31:0] f_hh;
  logic [2:0][47:0] f_hl;
  logic [2:0][63:0] f_ll;
  logic [2:0][31:0] f_hh_next;
  logic [2:0][47:0] f_hl_next;
  logic [2:0][63:0] f_ll_next;

  always_comb begin
    logic [NRM_W-1:0] m;
    for (int k = 0; k < 3; k++) begin
      m = mag48(e_side.nrm[k]);
      f_hh_next[k] = m[47:32] * m[47:32];
      f_hl_next[k] = m[47:32] * m[31:0];
      f_ll_next[k] = m[31:0] * m[31:0];
    end
  end

  // Stage G: sum of squares.
  logic        g_vld;
  side_t       g_side;
  logic [95:0] g_sum;
  logic [95:0] g_sum_next;

  always_comb begin
    g_sum_next = '0;
    for (int k = 0; k < 3; k++) begin
      g_sum_next = g_sum_next + {f_hh[k], 64'b0} + {15'b0, f_hl[k], 33'b0}
                 + {32'b0, f_ll[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid && func == FUNC_EVAL;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
      f_vld <= e_vld;
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_w    <= a_w_next;
      a_c    <= store;
      a_d    <= a_d_next;
      b_p    <= b_p_next;
      b_c    <= a_c;
      b_jp   <= b_jp_next;
      c_mp   <= c_mp_next;
      c_jd   <= c_jd_next;
      c_je   <= c_je_next;
      d_phys <= d_phys_next;
      d_x    <= d_x_next;
      e_side <= e_side_next;
      f_side <= e_side;
      f_hh   <= f_hh_next;
      f_hl   <= f_hl_next;
      f_ll   <= f_ll_next;
      g_side <= f_side;
      g_sum  <= g_sum_next;
    end
  end

  // Square root of the scaled sum, then the three normalizing divisions.
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  bqf_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_vld),
    .in_rad    ({g_sum, 30'b0}),
    .in_side   (g_side),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic                  dv_vld;
  logic [2:0][QUO_W-1:0] dv_quo;
  logic [ROOT_W-1:0]     dv_root;
  side_t                 dv_side;

  bqf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_vld),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_vld),
    .out_quo   (dv_quo),
    .out_root  (dv_root),
    .out_side  (dv_side)
  );

  // Output register.
  logic [46:0]      meas_next;
  logic [2:0][31:0] unit_next;
  logic             deg_next;

  always_comb begin
    logic [63:0] mr;
    logic [32:0] u33;
    logic [31:0] u;
    deg_next = (dv_side.nrm == '0);
    mr = {1'b0, dv_root} + 64'd16384;
    if (mr[63:15] > MEAS_MAX) meas_next = MEAS_MAX[46:0];
    else meas_next = mr[61:15];
    for (int k = 0; k < 3; k++) begin
      u33 = {1'b0, dv_quo[k]} + 33'd1;
      u = u33[32:1];
      if (u > UNIT_ONE) u = UNIT_ONE;
      unit_next[k] = dv_side.nrm[k][NRM_W-1] ? (~u + 32'd1) : u;
    end
    if (deg_next) begin
      meas_next = '0;
      unit_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phys_x          <= dv_side.phys[0];
      phys_y          <= dv_side.phys[1];
      phys_z          <= dv_side.phys[2];
      area_normal_x   <= dv_side.nrm[0];
      area_normal_y   <= dv_side.nrm[1];
      area_normal_z   <= dv_side.nrm[2];
      surface_measure <= meas_next;
      unit_normal_x   <= unit_next[0];
      unit_normal_y   <= unit_next[1];
      unit_normal_z   <= unit_next[2];
      degenerate      <= deg_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bqf_sqrt.sv
// ----------------------------------------------------------------------------
// bqf_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [bqf_pkg::RAD_W-1:0]   in_rad,
  input  bqf_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [bqf_pkg::ROOT_W-1:0]  out_root,
  output bqf_pkg::side_t              out_side
);
  import bqf_pkg::*;

  logic              vld_q  [SQ_STEPS];
  logic [RAD_W-1:0]  rad_q  [SQ_STEPS];
  logic [REM_W-1:0]  rem_q  [SQ_STEPS];
  logic [ROOT_W-1:0] root_q [SQ_STEPS];
  side_t             side_q [SQ_STEPS];

  logic              vld_s  [SQ_STEPS];
  logic [RAD_W-1:0]  rad_s  [SQ_STEPS];
  logic [REM_W-1:0]  rem_s  [SQ_STEPS];
  logic [ROOT_W-1:0] root_s [SQ_STEPS];
  side_t             side_s [SQ_STEPS];

  logic [RAD_W-1:0]  rad_next  [SQ_STEPS];
  logic [REM_W-1:0]  rem_next  [SQ_STEPS];
  logic [ROOT_W-1:0] root_next [SQ_STEPS];

  always_comb begin
    vld_s[0]  = in_valid;
    rad_s[0]  = in_rad;
    rem_s[0]  = '0;
    root_s[0] = '0;
    side_s[0] = in_side;
    for (int g = 1; g < SQ_STEPS; g++) begin
      vld_s[g]  = vld_q[g-1];
      rad_s[g]  = rad_q[g-1];
      rem_s[g]  = rem_q[g-1];
      root_s[g] = root_q[g-1];
      side_s[g] = side_q[g-1];
    end
  end

  always_comb begin
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;
    for (int g = 0; g < SQ_STEPS; g++) begin
      cur   = {rem_s[g], rad_s[g][RAD_W-1 -: 2]};
      trial = {2'b00, root_s[g], 2'b01};
      ge    = (cur >= trial);
      diff  = cur - trial;
      rem_next[g]  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      root_next[g] = {root_s[g][ROOT_W-2:0], ge};
      rad_next[g]  = {rad_s[g][RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < SQ_STEPS; g++) vld_q[g] <= 1'b0;
    end else if (en) begin
      for (int g = 0; g < SQ_STEPS; g++) vld_q[g] <= vld_s[g];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < SQ_STEPS; g++) begin
        rad_q[g]  <= rad_next[g];
        rem_q[g]  <= rem_next[g];
        root_q[g] <= root_next[g];
        side_q[g] <= side_s[g];
      end
    end
  end

  assign out_valid = vld_q[SQ_STEPS-1];
  assign out_root  = root_q[SQ_STEPS-1];
  assign out_side  = side_q[SQ_STEPS-1];

endmodule

`default_nettype wire

// File: rtl/core/bqf_div.sv
// ----------------------------------------------------------------------------
// bqf_div
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [bqf_pkg::ROOT_W-1:0]       in_root,
  input  bqf_pkg::side_t                   in_side,
  output logic                             out_valid,
  output logic [2:0][bqf_pkg::QUO_W-1:0]   out_quo,
  output logic [bqf_pkg::ROOT_W-1:0]       out_root,
  output bqf_pkg::side_t                   out_side
);
  import bqf_pkg::*;

  logic                   vld_q  [DV_STEPS];
  logic [2:0][DREM_W-1:0] rem_q  [DV_STEPS];
  logic [2:0][QUO_W-1:0]  quo_q  [DV_STEPS];
  logic [ROOT_W-1:0]      root_q [DV_STEPS];
  side_t                  side_q [DV_STEPS];

  logic                   vld_s  [DV_STEPS];
  logic [2:0][DREM_W-1:0] rem_s  [DV_STEPS];
  logic [2:0][QUO_W-1:0]  quo_s  [DV_STEPS];
  logic [ROOT_W-1:0]      root_s [DV_STEPS];
  side_t                  side_s [DV_STEPS];

  logic [2:0][DREM_W-1:0] rem_next [DV_STEPS];
  logic [2:0][QUO_W-1:0]  quo_next [DV_STEPS];

  always_comb begin
    vld_s[0]  = in_valid;
    root_s[0] = in_root;
    side_s[0] = in_side;
    quo_s[0]  = '0;
    for (int c = 0; c < 3; c++) begin
      rem_s[0][c] = {1'b0, mag48(in_side.nrm[c]), 14'b0};
    end
    for (int g = 1; g < DV_STEPS; g++) begin
      vld_s[g]  = vld_q[g-1];
      rem_s[g]  = rem_q[g-1];
      quo_s[g]  = quo_q[g-1];
      root_s[g] = root_q[g-1];
      side_s[g] = side_q[g-1];
    end
  end

  always_comb begin
    logic [DREM_W:0] shl;
    logic [DREM_W:0] dvs;
    logic [DREM_W:0] diff;
    logic            ge;
    for (int g = 0; g < DV_STEPS; g++) begin
      dvs = {1'b0, root_s[g]};
      for (int c = 0; c < 3; c++) begin
        shl  = {rem_s[g][c], 1'b0};
        ge   = (shl >= dvs);
        diff = shl - dvs;
        rem_next[g][c] = ge ? diff[DREM_W-1:0] : shl[DREM_W-1:0];
        quo_next[g][c] = {quo_s[g][c][QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < DV_STEPS; g++) vld_q[g] <= 1'b0;
    end else if (en) begin
      for (int g = 0; g < DV_STEPS; g++) vld_q[g] <= vld_s[g];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < DV_STEPS; g++) begin
        rem_q[g]  <= rem_next[g];
        quo_q[g]  <= quo_next[g];
        root_q[g] <= root_s[g];
        side_q[g] <= side_s[g];
      end
    end
  end

  assign out_valid = vld_q[DV_STEPS-1];
  assign out_quo   = quo_q[DV_STEPS-1];
  assign out_root  = root_q[DV_STEPS-1];
  assign out_side  = side_q[DV_STEPS-1];

endmodule

`default_nettype wire
